[design/mte_pkg.sv]
// Shared types and constants of the table-driven Morse encoder.
package mte_pkg;

	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 4;
	localparam int PAT_W       = 15;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_ENCODE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		SYM_DOT        = 2'd0,
		SYM_DASH       = 2'd1,
		SYM_LETTER_GAP = 2'd2,
		SYM_WORD_GAP   = 2'd3
	} sym_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORD,
		ST_SYMS,
		ST_GAP
	} back_state_t;

	// One character's worth of work for the back end.
	typedef struct packed {
		logic             is_space;
		logic [LEN_W-1:0] len;
		logic [PAT_W-1:0] pattern;
	} cmd_t;

	// Command handshake from the front end into the queue.
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} front_out_t;

	// Command handshake from the queue into the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_out_t;

endpackage

[design/morse_table_encoder_core.sv]
// Top level of the table-driven Morse encoder.
// This block turns message bytes into Morse symbols using a dictionary that is
// loaded through the same input queue. An item with action 0 stores the code of
// one letter (up to MAX_CODE_SYMBOLS dots and dashes, bit i of code_pattern is
// symbol i, a dash when set) and produces no output; a longer code_length is
// clipped to MAX_CODE_SYMBOLS, and a later load of the same letter replaces the
// earlier one. An item with action 1 encodes one byte: a space gives a word gap
// and then a letter gap, a loaded letter gives its dots and dashes in order and
// then a letter gap, and any other byte gives nothing. The final symbol of each
// character has last set. The front end reads the dictionary memory in the
// cycle an item is accepted and classifies it in the next cycle, then hands a
// command to a two-entry queue. The back end takes a command in its idle state
// and then emits one symbol per cycle while pop keeps up. The input raises full
// only when the classified item cannot enter the queue, so a few characters can
// be accepted while the output is stalled. The output is a registered item:
// empty low means symbol and last are valid, and pop takes it. There is no
// clearing pass after reset; entries not yet loaded are simply marked absent.
module morse_table_encoder_core #(
	parameter int TABLE_ENTRIES    = 256,
	parameter int MAX_CODE_SYMBOLS = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic         action,
	input  logic [7:0]   character,
	input  logic [3:0]   code_length,
	input  logic [14:0]  code_pattern,
	output logic         empty,
	input  logic         pop,
	output logic [1:0]   symbol,
	output logic         last
);

	mte_pkg::front_out_t front_out;
	mte_pkg::queue_out_t queue_out;
	logic                queue_ready;
	logic                queue_pop;

	// Accepts items, holds the dictionary and turns encode items into commands.
	mte_front #(
		.TABLE_ENTRIES    (TABLE_ENTRIES),
		.MAX_CODE_SYMBOLS (MAX_CODE_SYMBOLS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.character    (character),
		.code_length  (code_length),
		.code_pattern (code_pattern),
		.queue_ready  (queue_ready),
		.front_out    (front_out)
	);

	// Decouples the front end from a stalled output.
	mte_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.front_out   (front_out),
		.queue_ready (queue_ready),
		.queue_out   (queue_out),
		.queue_pop   (queue_pop)
	);

	// Expands each command into its symbol sequence.
	mte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.queue_out (queue_out),
		.queue_pop (queue_pop),
		.empty     (empty),
		.pop       (pop),
		.symbol    (symbol),
		.last      (last)
	);

endmodule

[design/mte_front.sv]
// Front end: accepts items, keeps the dictionary and classifies encode items.
module mte_front #(
	parameter int TABLE_ENTRIES    = 256,
	parameter int MAX_CODE_SYMBOLS = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        action,
	input  logic [mte_pkg::CHAR_W-1:0]  character,
	input  logic [mte_pkg::LEN_W-1:0]   code_length,
	input  logic [mte_pkg::PAT_W-1:0]   code_pattern,
	input  logic                        queue_ready,
	output mte_pkg::front_out_t         front_out
);

	localparam int ADDR_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ENTRY_W = mte_pkg::LEN_W + MAX_CODE_SYMBOLS;

	logic [ENTRY_W-1:0]       mem [TABLE_ENTRIES];
	logic [ENTRY_W-1:0]       rd_data_s1;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic                     valid_s1;
	logic                     is_space_s1;
	logic                     hit_s1;

	logic                     accept;
	logic                     is_load;
	logic                     is_encode;
	logic                     in_range;
	logic [ADDR_W-1:0]        addr;
	logic [mte_pkg::LEN_W-1:0] len_sat;
	logic                     s1_push;
	logic                     s1_free;

	assign addr      = character[ADDR_W-1:0];
	assign in_range  = ({1'b0, character} < (mte_pkg::CHAR_W + 1)'(TABLE_ENTRIES));
	assign is_load   = (mte_pkg::action_t'(action) == mte_pkg::ACT_LOAD);
	assign is_encode = (mte_pkg::action_t'(action) == mte_pkg::ACT_ENCODE);
	assign len_sat   = (code_length > mte_pkg::LEN_W'(MAX_CODE_SYMBOLS))
		? mte_pkg::LEN_W'(MAX_CODE_SYMBOLS) : code_length;

	assign s1_push = valid_s1 && (is_space_s1 || hit_s1);
	assign s1_free = !s1_push || queue_ready;
	assign full    = valid_s1 && !s1_free;
	assign accept  = push && !full;

	// Dictionary storage; entries are undefined until a load writes them.
	always_ff @(posedge clk) begin
		if (accept && is_load && in_range) begin
			mem[addr] <= {len_sat, code_pattern[MAX_CODE_SYMBOLS-1:0]};
		end
		if (accept && is_encode) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept && is_load && in_range) begin
				valid_q[addr] <= 1'b1;
			end
			if (accept && is_encode) begin
				valid_s1 <= 1'b1;
			end else if (s1_free) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_encode) begin
			is_space_s1 <= (character == mte_pkg::SPACE_CHAR);
			hit_s1      <= in_range && valid_q[addr];
		end
	end

	always_comb begin
		front_out.push             = s1_push;
		front_out.cmd.is_space     = is_space_s1;
		front_out.cmd.len          = rd_data_s1[ENTRY_W-1 -: mte_pkg::LEN_W];
		front_out.cmd.pattern      = mte_pkg::PAT_W'(rd_data_s1[MAX_CODE_SYMBOLS-1:0]);
	end

endmodule

[design/mte_queue.sv]
// Short command queue between the front end and the back end.
module mte_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  mte_pkg::front_out_t front_out,
	output logic                queue_ready,
	output mte_pkg::queue_out_t queue_out,
	input  logic                queue_pop
);

	localparam int PTR_W = $clog2(mte_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mte_pkg::QUEUE_DEPTH + 1);

	mte_pkg::cmd_t     slots_q [mte_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign queue_ready     = (count_q != CNT_W'(mte_pkg::QUEUE_DEPTH));
	assign queue_out.valid = (count_q != '0);
	assign queue_out.cmd   = slots_q[rd_ptr_q];
	assign do_push         = front_out.push && queue_ready;
	assign do_pop          = queue_pop && queue_out.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= front_out.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// The front end holds its command rather than pushing into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!queue_ready |-> !do_push)
		else $error("queue written while full");

	// Pops only happen while something is stored.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !do_pop)
		else $error("queue popped while empty");

endmodule

[design/mte_back.sv]
// Back end: expands one command into Morse symbols and holds the output item.
module mte_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mte_pkg::queue_out_t queue_out,
	output logic                queue_pop,
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          symbol,
	output logic                last
);

	mte_pkg::back_state_t        state_q;
	mte_pkg::back_state_t        state_d;
	logic [mte_pkg::PAT_W-1:0]   pat_q;
	logic [mte_pkg::LEN_W-1:0]   cnt_q;
	logic                        out_valid_q;
	mte_pkg::sym_t               sym_q;
	logic                        last_q;

	logic                        advance;
	logic                        load_cmd;
	logic                        emit;
	logic                        shift;
	mte_pkg::sym_t               emit_sym;
	logic                        emit_last;

	assign advance = !out_valid_q || pop;
	assign empty   = !out_valid_q;
	assign symbol  = sym_q;
	assign last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		load_cmd  = 1'b0;
		emit      = 1'b0;
		shift     = 1'b0;
		emit_sym  = mte_pkg::SYM_LETTER_GAP;
		emit_last = 1'b0;
		unique case (state_q)
			mte_pkg::ST_IDLE: begin
				if (queue_out.valid) begin
					load_cmd = 1'b1;
					if (queue_out.cmd.is_space) begin
						state_d = mte_pkg::ST_WORD;
					end else if (queue_out.cmd.len != '0) begin
						state_d = mte_pkg::ST_SYMS;
					end else begin
						state_d = mte_pkg::ST_GAP;
					end
				end
			end
			mte_pkg::ST_WORD: begin
				if (advance) begin
					emit     = 1'b1;
					emit_sym = mte_pkg::SYM_WORD_GAP;
					state_d  = mte_pkg::ST_GAP;
				end
			end
			mte_pkg::ST_SYMS: begin
				if (advance) begin
					emit     = 1'b1;
					shift    = 1'b1;
					emit_sym = pat_q[0] ? mte_pkg::SYM_DASH : mte_pkg::SYM_DOT;
					if (cnt_q == mte_pkg::LEN_W'(1)) begin
						state_d = mte_pkg::ST_GAP;
					end
				end
			end
			mte_pkg::ST_GAP: begin
				if (advance) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = mte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mte_pkg::ST_IDLE;
			end
		endcase
	end

	assign queue_pop = load_cmd;

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			pat_q <= queue_out.cmd.pattern;
			cnt_q <= queue_out.cmd.len;
		end else if (shift) begin
			pat_q <= pat_q >> 1;
			cnt_q <= cnt_q - mte_pkg::LEN_W'(1);
		end
		if (emit) begin
			sym_q  <= emit_sym;
			last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	// Only the closing letter gap of a character carries the last mark.
	a_last_on_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (sym_q == mte_pkg::SYM_LETTER_GAP))
		else $error("last set on a symbol other than the letter gap");

	// A taken word gap is followed at once by the letter gap that closes the space.
	a_word_then_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pop && sym_q == mte_pkg::SYM_WORD_GAP) |=>
		(out_valid_q && last_q && sym_q == mte_pkg::SYM_LETTER_GAP))
		else $error("word gap not followed by letter gap");

	// A new command is only taken once the previous character is finished.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_cmd |-> (state_q == mte_pkg::ST_IDLE))
		else $error("command taken while a character is in progress");

endmodule
